/* src/cau_pkg.sv */
// Shared types, constants and codes for the complex arithmetic unit.
// Used by every module of the unit; depends on nothing.
`default_nettype none
package cau_pkg;

  localparam int WORD_BITS = 16;
  localparam int FRAC_BITS = 8;
  // exact magnitude of a product sum, divisor and quotient widths
  localparam int MAG_W = 2 * WORD_BITS;
  localparam int QW = WORD_BITS + 1;
  localparam int NUM_W = MAG_W + FRAC_BITS;
  // one divider stage per quotient bit
  localparam int DIV_STAGES = QW;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_DZ  = 2'd1,
    STAT_SAT = 2'd2
  } stat_t;

  localparam logic signed [WORD_BITS-1:0] RES_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] RES_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // one result part as sign and magnitude, plus divider working state
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] rem;
    logic [QW-1:0]    nb;
    logic [QW-1:0]    q;
    logic             ovf;
  } part_t;

  typedef struct packed {
    op_t              op;
    logic             dz;
    logic [MAG_W-1:0] den;
    part_t            re;
    part_t            im;
  } item_t;

endpackage
`default_nettype wire

/* src/complex_arith_unit.sv */
// Complex add / subtract / multiply / divide on signed Q8.8 operands.
// Pipeline: 3 front stages, 17 divider stages, one for each quotient bit,
// and the output register, from input transaction to result.
// Throughput: one transaction per cycle; the whole pipeline holds when the
// output is stalled. Synchronous active-high reset clears all valid bits.
`default_nettype none
module complex_arith_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         opcode,
  input  wire logic signed [cau_pkg::WORD_BITS-1:0] a_real,
  input  wire logic signed [cau_pkg::WORD_BITS-1:0] a_imag,
  input  wire logic signed [cau_pkg::WORD_BITS-1:0] b_real,
  input  wire logic signed [cau_pkg::WORD_BITS-1:0] b_imag,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [cau_pkg::WORD_BITS-1:0]    res_real,
  output logic signed [cau_pkg::WORD_BITS-1:0]    res_imag,
  output logic [1:0]                              status
);

  logic en;
  logic vld [0:cau_pkg::DIV_STAGES];
  cau_pkg::item_t itm [0:cau_pkg::DIV_STAGES];

  // pipeline moves whenever the output slot is free or taken
  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  cau_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .opcode(opcode), .a_real(a_real), .a_imag(a_imag),
    .b_real(b_real), .b_imag(b_imag),
    .out_valid(vld[0]), .out_item(itm[0])
  );

  // divider chain
  for (genvar i = 0; i < cau_pkg::DIV_STAGES; i++) begin : g_div
    cau_div_step u_step (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(vld[i]), .in_item(itm[i]),
      .out_valid(vld[i+1]), .out_item(itm[i+1])
    );
  end

  cau_back u_back (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vld[cau_pkg::DIV_STAGES]), .in_item(itm[cau_pkg::DIV_STAGES]),
    .out_valid(out_valid), .res_real(res_real), .res_imag(res_imag),
    .status(status)
  );

  // checks
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output free");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == cau_pkg::STAT_DZ) |-> (res_real == '0 && res_imag == '0))
    else $error("divide by zero result not zero");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == cau_pkg::STAT_SAT) |->
      (res_real == cau_pkg::RES_MAX || res_real == cau_pkg::RES_MIN ||
       res_imag == cau_pkg::RES_MAX || res_imag == cau_pkg::RES_MIN))
    else $error("saturated status without extreme part");

endmodule
`default_nettype wire

/* src/cau_front.sv */
// Front end: input register, product stage and sum / sign-magnitude stage.
// Depends on cau_pkg.
`default_nettype none
module cau_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic [1:0]                        opcode,
  input  wire logic signed [cau_pkg::WORD_BITS-1:0] a_real,
  input  wire logic signed [cau_pkg::WORD_BITS-1:0] a_imag,
  input  wire logic signed [cau_pkg::WORD_BITS-1:0] b_real,
  input  wire logic signed [cau_pkg::WORD_BITS-1:0] b_imag,
  output logic                                   out_valid,
  output cau_pkg::item_t                         out_item
);

  localparam int SW = cau_pkg::MAG_W + 2;

  // stage A: operand register
  logic va;
  cau_pkg::op_t op_a;
  logic signed [cau_pkg::WORD_BITS-1:0] a_a, b_a, c_a, d_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_a <= cau_pkg::op_t'(opcode);
      a_a <= a_real;
      b_a <= a_imag;
      c_a <= b_real;
      d_a <= b_imag;
    end
  end

  // stage B: six products in parallel
  logic vb;
  cau_pkg::op_t op_b;
  logic signed [cau_pkg::WORD_BITS-1:0] a_b, b_b, c_b, d_b;
  logic signed [cau_pkg::MAG_W-1:0] ac, bd, ad, bc, cc, dd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_b <= op_a;
      a_b <= a_a;
      b_b <= b_a;
      c_b <= c_a;
      d_b <= d_a;
      ac <= a_a * c_a;
      bd <= b_a * d_a;
      ad <= a_a * d_a;
      bc <= b_a * c_a;
      cc <= c_a * c_a;
      dd <= d_a * d_a;
    end
  end

  // stage C: sums, sign-magnitude, divider setup
  logic signed [SW-1:0] re_s, im_s, re_abs, im_abs;
  logic [cau_pkg::MAG_W-1:0] re_mag, im_mag, den;
  logic [cau_pkg::NUM_W-1:0] re_num, im_num;

  always_comb begin
    unique case (op_b)
      cau_pkg::OP_ADD: begin
        re_s = SW'(a_b) + SW'(c_b);
        im_s = SW'(b_b) + SW'(d_b);
      end
      cau_pkg::OP_SUB: begin
        re_s = SW'(a_b) - SW'(c_b);
        im_s = SW'(b_b) - SW'(d_b);
      end
      cau_pkg::OP_MUL: begin
        re_s = SW'(ac) - SW'(bd);
        im_s = SW'(ad) + SW'(bc);
      end
      default: begin
        re_s = SW'(ac) + SW'(bd);
        im_s = SW'(bc) - SW'(ad);
      end
    endcase
    re_abs = re_s[SW-1] ? -re_s : re_s;
    im_abs = im_s[SW-1] ? -im_s : im_s;
    re_mag = re_abs[cau_pkg::MAG_W-1:0];
    im_mag = im_abs[cau_pkg::MAG_W-1:0];
    // multiply drops fraction bits of the exact magnitude
    if (op_b == cau_pkg::OP_MUL) begin
      re_mag = re_mag >> cau_pkg::FRAC_BITS;
      im_mag = im_mag >> cau_pkg::FRAC_BITS;
    end
    den = cau_pkg::MAG_W'(cc) + cau_pkg::MAG_W'(dd);
    re_num = {re_mag, {cau_pkg::FRAC_BITS{1'b0}}};
    im_num = {im_mag, {cau_pkg::FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.op <= op_b;
      out_item.dz <= (c_b == '0) && (d_b == '0);
      out_item.den <= den;
      out_item.re.neg <= re_s[SW-1];
      out_item.re.mag <= re_mag;
      out_item.re.rem <= cau_pkg::MAG_W'(re_num >> cau_pkg::QW);
      out_item.re.nb <= re_num[cau_pkg::QW-1:0];
      out_item.re.q <= '0;
      // quotient would need more than QW bits
      out_item.re.ovf <= (re_num >> cau_pkg::QW) >= cau_pkg::NUM_W'(den);
      out_item.im.neg <= im_s[SW-1];
      out_item.im.mag <= im_mag;
      out_item.im.rem <= cau_pkg::MAG_W'(im_num >> cau_pkg::QW);
      out_item.im.nb <= im_num[cau_pkg::QW-1:0];
      out_item.im.q <= '0;
      out_item.im.ovf <= (im_num >> cau_pkg::QW) >= cau_pkg::NUM_W'(den);
    end
  end

endmodule
`default_nettype wire

/* src/cau_div_step.sv */
// One registered restoring-division step for both result parts.
// Depends on cau_pkg.
`default_nettype none
module cau_div_step (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  cau_pkg::item_t      in_item,
  output logic                out_valid,
  output cau_pkg::item_t      out_item
);

  function automatic cau_pkg::part_t step(cau_pkg::part_t p, logic [cau_pkg::MAG_W-1:0] den);
    logic [cau_pkg::MAG_W:0] t;
    cau_pkg::part_t r;
    r = p;
    t = {p.rem, p.nb[cau_pkg::QW-1]};
    if (t >= {1'b0, den}) begin
      t = t - {1'b0, den};
      r.q = {p.q[cau_pkg::QW-2:0], 1'b1};
    end else begin
      r.q = {p.q[cau_pkg::QW-2:0], 1'b0};
    end
    r.rem = t[cau_pkg::MAG_W-1:0];
    r.nb = p.nb << 1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.op <= in_item.op;
      out_item.dz <= in_item.dz;
      out_item.den <= in_item.den;
      out_item.re <= step(in_item.re, in_item.den);
      out_item.im <= step(in_item.im, in_item.den);
    end
  end

endmodule
`default_nettype wire

/* src/cau_back.sv */
// Back end: result select, saturation, status and output register.
// Depends on cau_pkg.
`default_nettype none
module cau_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            en,
  input  wire logic                            in_valid,
  input  cau_pkg::item_t                       in_item,
  output logic                                 out_valid,
  output logic signed [cau_pkg::WORD_BITS-1:0] res_real,
  output logic signed [cau_pkg::WORD_BITS-1:0] res_imag,
  output logic [1:0]                           status
);

  localparam int VW = cau_pkg::MAG_W + 1;

  typedef struct packed {
    logic                         sat;
    logic [cau_pkg::WORD_BITS-1:0] val;
  } nar_t;

  function automatic nar_t narrow(cau_pkg::part_t p, logic is_div);
    logic [VW-1:0] v;
    nar_t r;
    if (is_div) begin
      v = p.ovf ? '1 : VW'(p.q);
    end else begin
      v = VW'(p.mag);
    end
    if (!p.neg) begin
      r.sat = v > VW'(cau_pkg::RES_MAX);
      r.val = r.sat ? cau_pkg::RES_MAX : v[cau_pkg::WORD_BITS-1:0];
    end else begin
      r.sat = v > VW'({1'b0, cau_pkg::RES_MIN});
      r.val = r.sat ? cau_pkg::RES_MIN : cau_pkg::WORD_BITS'(-v);
    end
    return r;
  endfunction

  nar_t nre, nim;
  logic is_div;

  always_comb begin
    is_div = in_item.op == cau_pkg::OP_DIV;
    nre = narrow(in_item.re, is_div);
    nim = narrow(in_item.im, is_div);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (is_div && in_item.dz) begin
        res_real <= '0;
        res_imag <= '0;
        status <= cau_pkg::STAT_DZ;
      end else begin
        res_real <= nre.val;
        res_imag <= nim.val;
        status <= (nre.sat || nim.sat) ? cau_pkg::STAT_SAT : cau_pkg::STAT_OK;
      end
    end
  end

endmodule
`default_nettype wire

/* test/cau_checker.sv */
// Checker for the complex arithmetic unit: watches both channels, predicts each result.
// Compares every result transaction in order; depends on cau_pkg.
`default_nettype none
module cau_checker (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic                     in_stall,
  input  wire logic [1:0]               opcode,
  input  wire logic signed [15:0]       a_real,
  input  wire logic signed [15:0]       a_imag,
  input  wire logic signed [15:0]       b_real,
  input  wire logic signed [15:0]       b_imag,
  input  wire logic                     out_valid,
  input  wire logic                     out_stall,
  input  wire logic signed [15:0]       res_real,
  input  wire logic signed [15:0]       res_imag,
  input  wire logic [1:0]               status,
  output int                            errors,
  output int                            pending,
  output int                            n_checked,
  output int                            n_dz,
  output int                            n_sat
);

  typedef struct {
    logic signed [cau_pkg::WORD_BITS-1:0] re;
    logic signed [cau_pkg::WORD_BITS-1:0] im;
    cau_pkg::stat_t                       st;
  } cplx_result_t;

  cplx_result_t results_due[$];

  // clamp one exact part to the word range, noting saturation
  function automatic logic signed [cau_pkg::WORD_BITS-1:0] clamp_part(longint v,
                                                                      inout bit hit);
    if (v > longint'(cau_pkg::RES_MAX)) begin
      hit = 1;
      return cau_pkg::RES_MAX;
    end
    if (v < longint'(cau_pkg::RES_MIN)) begin
      hit = 1;
      return cau_pkg::RES_MIN;
    end
    return v[cau_pkg::WORD_BITS-1:0];
  endfunction

  // exact complex arithmetic, truncated toward zero, then saturated; a zero divisor gives zero
  function automatic cplx_result_t complex_result(cau_pkg::op_t op, longint a, longint b,
                                                  longint c, longint d);
    cplx_result_t r;
    longint re, im, den;
    bit hit;
    hit = 0;
    re = 0;
    im = 0;
    case (op)
      cau_pkg::OP_ADD: begin
        re = a + c;
        im = b + d;
      end
      cau_pkg::OP_SUB: begin
        re = a - c;
        im = b - d;
      end
      cau_pkg::OP_MUL: begin
        re = (a * c - b * d) / (longint'(1) << cau_pkg::FRAC_BITS);
        im = (a * d + b * c) / (longint'(1) << cau_pkg::FRAC_BITS);
      end
      default: begin
        if (c == 0 && d == 0) begin
          r.re = '0;
          r.im = '0;
          r.st = cau_pkg::STAT_DZ;
          return r;
        end
        den = c * c + d * d;
        re = ((a * c + b * d) * (longint'(1) << cau_pkg::FRAC_BITS)) / den;
        im = ((b * c - a * d) * (longint'(1) << cau_pkg::FRAC_BITS)) / den;
      end
    endcase
    r.re = clamp_part(re, hit);
    r.im = clamp_part(im, hit);
    r.st = hit ? cau_pkg::STAT_SAT : cau_pkg::STAT_OK;
    return r;
  endfunction

  assign pending = results_due.size();

  // predict on each input transaction, compare on each output transaction
  always @(posedge clk) begin
    cplx_result_t want;
    if (rst) begin
      errors <= 0;
      n_checked <= 0;
      n_dz <= 0;
      n_sat <= 0;
    end else begin
      if (in_valid && !in_stall)
        results_due.push_back(complex_result(cau_pkg::op_t'(opcode), a_real, a_imag,
                                             b_real, b_imag));
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result re=%0d im=%0d st=%0d", $time,
                   res_real, res_imag, status);
          errors <= errors + 1;
        end else begin
          want = results_due.pop_front();
          n_checked <= n_checked + 1;
          if (want.st == cau_pkg::STAT_DZ) n_dz <= n_dz + 1;
          if (want.st == cau_pkg::STAT_SAT) n_sat <= n_sat + 1;
          if (res_real !== want.re || res_imag !== want.im || status !== want.st) begin
            $display("%0t: mismatch expected re=%0d im=%0d st=%0d, got re=%0d im=%0d st=%0d",
                     $time, want.re, want.im, want.st, res_real, res_imag, status);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

/* test/testbench.sv */
// Top of the complex arithmetic unit testbench: clock, reset, stimulus and verdict.
// Depends on cau_pkg, complex_arith_unit and cau_checker.
`default_nettype none
module testbench;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] opcode, status;
  logic signed [15:0] a_real, a_imag, b_real, b_imag, res_real, res_imag;
  int errors, pending, n_checked, n_dz, n_sat;
  int stall_mode;

  complex_arith_unit dut (.*);

  cau_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("testbench failed");
    $finish;
  end

  // receiver stall pattern: switches between none, light and heavy
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // one input transaction, held until accepted
  task automatic send_op(cau_pkg::op_t op, logic signed [15:0] ar, ai, br, bi);
    in_valid <= 1;
    opcode <= op;
    a_real <= ar;
    a_imag <= ai;
    b_real <= br;
    b_imag <= bi;
    do @(posedge clk); while (in_stall);
  endtask

  // operand value: full range, small, or extreme
  function automatic logic signed [15:0] pick_word();
    case ($urandom_range(0, 5))
      0, 1: return 16'($urandom);
      2, 3: return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
      4: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return $signed(16'($urandom_range(0, 63))) - 16'sd32;
    endcase
  endfunction

  initial begin
    logic signed [15:0] br, bi;
    int burst;
    rst = 1;
    in_valid = 0;
    opcode = 0;
    a_real = 0;
    a_imag = 0;
    b_real = 0;
    b_imag = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: each op at extremes, zero divisor, one-part-zero divisors
    send_op(cau_pkg::OP_ADD, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_op(cau_pkg::OP_ADD, 16'sh0100, -16'sh0080, 16'sh0001, 16'sh0002);
    send_op(cau_pkg::OP_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_op(cau_pkg::OP_SUB, 16'sh0300, 16'sh0100, 16'sh0100, 16'sh0300);
    send_op(cau_pkg::OP_MUL, 16'sh0200, 16'sh0100, 16'sh0100, -16'sh0100);
    send_op(cau_pkg::OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_op(cau_pkg::OP_MUL, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_op(cau_pkg::OP_MUL, -16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001);
    send_op(cau_pkg::OP_DIV, 16'sh0400, 16'sh0200, 16'sh0000, 16'sh0000);
    send_op(cau_pkg::OP_DIV, 16'sh0400, 16'sh0200, 16'sh0000, 16'sh0100);
    send_op(cau_pkg::OP_DIV, 16'sh0400, 16'sh0200, 16'sh0200, 16'sh0000);
    send_op(cau_pkg::OP_DIV, 16'sh7fff, 16'sh8000, 16'sh0001, 16'sh0000);
    send_op(cau_pkg::OP_DIV, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_op(cau_pkg::OP_DIV, -16'sh0001, 16'sh0001, 16'sh7fff, 16'sh7fff);
    send_op(cau_pkg::OP_DIV, 16'sh0100, 16'sh0000, 16'sh0003, 16'sh0000);
    send_op(cau_pkg::OP_DIV, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_op(cau_pkg::OP_ADD, 16'shffff, 16'shffff, 16'shffff, 16'shffff);
    send_op(cau_pkg::OP_MUL, 16'sh0000, 16'sh0000, 16'sh7fff, 16'sh8000);
    in_valid <= 0;

    // hold off until the pipeline has drained
    wait (pending == 0);
    @(posedge clk);

    // random bursts with gaps
    for (int n = 0; n < 950; ) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst; k++) begin
        br = pick_word();
        bi = pick_word();
        if ($urandom_range(0, 15) == 0) begin
          br = 0;
          bi = 0;
        end else if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1)) br = 0; else bi = 0;
        end
        send_op(cau_pkg::op_t'($urandom_range(0, 3)), pick_word(), pick_word(), br, bi);
        n++;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_valid <= 0;

    wait (pending == 0);
    repeat (40) @(posedge clk);
    $display("checked %0d results: %0d divide by zero, %0d saturated, all four ops",
             n_checked, n_dz, n_sat);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
src/cau_pkg.sv
src/cau_front.sv
src/cau_div_step.sv
src/cau_back.sv
src/complex_arith_unit.sv
test/cau_checker.sv
test/testbench.sv
